### design/absm_pkg.sv
// Package with opcodes, status codes, defaults and key ordering for the sorted map.
package absm_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_PRESENT = 2'd0;
  localparam logic [1:0] ST_ABSENT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  function automatic logic goes_left(input logic [31:0] a, input logic [31:0] b,
                                     input logic descending);
    logic lt;
    logic gt;
    lt = $signed(a) < $signed(b);
    gt = $signed(a) > $signed(b);
    return descending ? gt : lt;
  endfunction

endpackage

### design/array_bst_sorted_map_unit.sv
// Sorted key-value map held as a binary search tree in a node RAM with a free-slot list.
// Each tree level walked takes a node read (S_WRD) and a compare (S_WCMP), then update states and the reply.
// One beat at a time: the next beat is taken once the reply is registered.
// Two-child removes also walk the successor search, with a read (S_SRD) and compare (S_SCMP) per level.
// Reset: synchronous, active low; a clear pass (S_CLEAR) then chains every free-list slot,
// during which no input beat is taken.
module array_bst_sorted_map_unit #(
  parameter int CAPACITY = absm_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic                          cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic signed [31:0]            in_key,
  input  logic signed [31:0]            in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic signed [31:0]            out_old_value,
  output logic [$clog2(CAPACITY):0]     out_entry_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = AW + 1;
  localparam int NW = 64 + 2 * LW;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRD, S_WCMP, S_INS_NODE, S_INS_PAR, S_REPL,
    S_SRD, S_SCMP, S_SPW, S_FREE_WR, S_RESP
  } state_t;

  state_t state_r;

  logic [1:0]    op_r;
  logic [31:0]   key_r;
  logic [31:0]   val_r;
  logic [LW-1:0] cur_r;
  logic [LW-1:0] par_r;
  logic          pdir_r;
  logic [NW-1:0] par_word_r;
  logic [NW-1:0] n_word_r;
  logic [LW-1:0] n_idx_r;
  logic [LW-1:0] s_r;
  logic [LW-1:0] sp_r;
  logic [NW-1:0] sp_word_r;
  logic [LW-1:0] repl_r;
  logic [LW-1:0] freed_r;
  logic [LW-1:0] slot_r;
  logic [LW-1:0] free_head_r;
  logic [LW-1:0] root_r;
  logic [LW-1:0] count_r;
  logic          order_r;
  logic [AW-1:0] clr_r;
  logic [1:0]    status_r;
  logic [31:0]   old_r;

  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_old_r;
  logic [LW-1:0] out_count_r;

  logic          node_we;
  logic [AW-1:0] node_waddr;
  logic [NW-1:0] node_wdata;
  logic          node_re;
  logic [AW-1:0] node_raddr;
  logic [NW-1:0] node_rdata;

  logic          free_we;
  logic [AW-1:0] free_waddr;
  logic [LW-1:0] free_wdata;
  logic          free_re;
  logic [AW-1:0] free_raddr;
  logic [LW-1:0] free_rdata;

  logic [31:0]   rd_key;
  logic [31:0]   rd_val;
  logic [LW-1:0] rd_left;
  logic [LW-1:0] rd_right;
  logic          rd_gl;

  assign rd_key   = node_rdata[NW-1 -: 32];
  assign rd_val   = node_rdata[NW-33 -: 32];
  assign rd_left  = node_rdata[2*LW-1 -: LW];
  assign rd_right = node_rdata[LW-1:0];
  assign rd_gl    = absm_pkg::goes_left(key_r, rd_key, order_r);

  absm_ram #(.WIDTH(NW), .DEPTH(CAPACITY)) u_node_ram (
    .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
    .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
  );

  absm_ram #(.WIDTH(LW), .DEPTH(CAPACITY)) u_free_ram (
    .clk(clk), .we(free_we), .waddr(free_waddr), .wdata(free_wdata),
    .re(free_re), .raddr(free_raddr), .rdata(free_rdata)
  );

  assign in_ready        = (state_r == S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_old_value   = out_old_r;
  assign out_entry_count = out_count_r;

  always_comb begin
    node_we    = 1'b0;
    node_waddr = cur_r[AW-1:0];
    node_wdata = node_rdata;
    node_re    = 1'b0;
    node_raddr = cur_r[AW-1:0];
    free_we    = 1'b0;
    free_waddr = freed_r[AW-1:0];
    free_wdata = free_head_r;
    free_re    = 1'b0;
    free_raddr = free_head_r[AW-1:0];
    case (state_r)
      S_CLEAR: begin
        free_we    = 1'b1;
        free_waddr = clr_r;
        free_wdata = LW'(clr_r) + LW'(1);
      end
      S_WRD: begin
        node_re = (cur_r < NIL);
        free_re = (cur_r >= NIL) && (op_r == absm_pkg::OP_INSERT);
      end
      S_WCMP: begin
        node_we    = (rd_key == key_r) && (op_r == absm_pkg::OP_INSERT);
        node_wdata = {rd_key, val_r, rd_left, rd_right};
      end
      S_INS_NODE: begin
        node_we    = 1'b1;
        node_waddr = free_head_r[AW-1:0];
        node_wdata = {key_r, val_r, NIL, NIL};
      end
      S_INS_PAR: begin
        node_we    = 1'b1;
        node_waddr = par_r[AW-1:0];
        node_wdata = pdir_r ? {par_word_r[NW-1 -: 64], slot_r, par_word_r[LW-1:0]}
                            : {par_word_r[NW-1 -: 64 + LW], slot_r};
      end
      S_REPL: begin
        node_we    = (par_r < NIL);
        node_waddr = par_r[AW-1:0];
        node_wdata = pdir_r ? {par_word_r[NW-1 -: 64], repl_r, par_word_r[LW-1:0]}
                            : {par_word_r[NW-1 -: 64 + LW], repl_r};
      end
      S_SRD: begin
        node_re    = 1'b1;
        node_raddr = s_r[AW-1:0];
      end
      S_SCMP: begin
        node_we    = (rd_left >= NIL);
        node_waddr = n_idx_r[AW-1:0];
        node_wdata = (sp_r == n_idx_r)
                   ? {rd_key, rd_val, n_word_r[2*LW-1 -: LW], rd_right}
                   : {rd_key, rd_val, n_word_r[2*LW-1:0]};
      end
      S_SPW: begin
        node_we    = 1'b1;
        node_waddr = sp_r[AW-1:0];
        node_wdata = {sp_word_r[NW-1 -: 64], repl_r, sp_word_r[LW-1:0]};
      end
      S_FREE_WR: begin
        free_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      root_r      <= NIL;
      free_head_r <= '0;
      count_r     <= '0;
      order_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        order_r <= cfg_data;
      end
      if (out_valid_r && out_ready && state_r != S_RESP) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CAPACITY - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_r     <= in_opcode;
            key_r    <= in_key;
            val_r    <= in_value;
            cur_r    <= root_r;
            par_r    <= NIL;
            status_r <= absm_pkg::ST_ABSENT;
            old_r    <= '0;
            if (in_opcode == absm_pkg::OP_INSERT || in_opcode == absm_pkg::OP_LOOKUP ||
                in_opcode == absm_pkg::OP_REMOVE) begin
              state_r <= S_WRD;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_WRD: begin
          if (cur_r < NIL) begin
            state_r <= S_WCMP;
          end else if (op_r == absm_pkg::OP_INSERT && free_head_r < NIL) begin
            state_r <= S_INS_NODE;
          end else begin
            if (op_r == absm_pkg::OP_INSERT) begin
              status_r <= absm_pkg::ST_FULL;
            end
            state_r <= S_RESP;
          end
        end
        S_WCMP: begin
          if (rd_key == key_r) begin
            status_r <= absm_pkg::ST_PRESENT;
            old_r    <= rd_val;
            n_idx_r  <= cur_r;
            n_word_r <= node_rdata;
            freed_r  <= cur_r;
            if (op_r == absm_pkg::OP_REMOVE) begin
              if (rd_left >= NIL) begin
                repl_r  <= rd_right;
                state_r <= S_REPL;
              end else if (rd_right >= NIL) begin
                repl_r  <= rd_left;
                state_r <= S_REPL;
              end else begin
                s_r       <= rd_right;
                sp_r      <= cur_r;
                sp_word_r <= node_rdata;
                state_r   <= S_SRD;
              end
            end else begin
              state_r <= S_RESP;
            end
          end else begin
            par_r      <= cur_r;
            par_word_r <= node_rdata;
            pdir_r     <= rd_gl;
            cur_r      <= rd_gl ? rd_left : rd_right;
            state_r    <= S_WRD;
          end
        end
        S_INS_NODE: begin
          free_head_r <= free_rdata;
          slot_r      <= free_head_r;
          count_r     <= count_r + LW'(1);
          if (par_r >= NIL) begin
            root_r  <= free_head_r;
            state_r <= S_RESP;
          end else begin
            state_r <= S_INS_PAR;
          end
        end
        S_INS_PAR: begin
          state_r <= S_RESP;
        end
        S_REPL: begin
          if (par_r >= NIL) begin
            root_r <= repl_r;
          end
          state_r <= S_FREE_WR;
        end
        S_SRD: begin
          state_r <= S_SCMP;
        end
        S_SCMP: begin
          if (rd_left < NIL) begin
            sp_r      <= s_r;
            sp_word_r <= node_rdata;
            s_r       <= rd_left;
            state_r   <= S_SRD;
          end else begin
            freed_r <= s_r;
            repl_r  <= rd_right;
            state_r <= (sp_r == n_idx_r) ? S_FREE_WR : S_SPW;
          end
        end
        S_SPW: begin
          state_r <= S_FREE_WR;
        end
        S_FREE_WR: begin
          free_head_r <= freed_r;
          if (count_r != '0) begin
            count_r <= count_r - LW'(1);
          end
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_old_r    <= old_r;
            out_count_r  <= count_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### design/absm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module absm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
